// ----- sv/clt_pkg.sv -----
`default_nettype none
package clt_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int RECS_PER_ITEM = 3;

   localparam logic [7:0] CH_A = 8'h61;
   localparam logic [7:0] CH_Z = 8'h7a;
   localparam logic [7:0] CH_0 = 8'h30;
   localparam logic [7:0] CH_9 = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_BLANK = 8'h20;

   localparam logic [3:0] KIND_CMD = 4'd0;
   localparam logic [3:0] KIND_NAME_ARG = 4'd1;
   localparam logic [3:0] KIND_NUM_ARG = 4'd2;
   localparam logic [3:0] KIND_LAST_RESULT = 4'd3;
   localparam logic [3:0] KIND_TYPE = 4'd4;
   localparam logic [3:0] KIND_OK = 4'd5;
   localparam logic [3:0] KIND_NO_NAME = 4'd6;
   localparam logic [3:0] KIND_BAD_ARG = 4'd7;
   localparam logic [3:0] KIND_TOO_LONG = 4'd8;

   typedef enum logic [3:0] {
      PH_START,
      PH_CNAME,
      PH_ARGS,
      PH_NAMEARG,
      PH_NUMARG,
      PH_DOLLAR,
      PH_VALDONE,
      PH_HASH,
      PH_TYPE
   } phase_type;

   typedef enum logic [1:0] {
      FAIL_NONE,
      FAIL_NONAME,
      FAIL_BAD,
      FAIL_LONG
   } fail_type;

   typedef struct packed {
      logic [7:0]  character;
      logic        has_character;
      logic        end_of_line;
      logic [15:0] line_number;
   } req_type;

   typedef struct packed {
      logic [3:0]  record_kind;
      logic [9:0]  start_column;
      logic [10:0] token_length;
      logic [15:0] line_echo;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [3:0]  kind;
      logic [9:0]  start;
      logic [10:0] len;
   } rec_type;

   typedef struct packed {
      rec_type [RECS_PER_ITEM-1:0] recs;
      logic [15:0]                 line;
   } bundle_type;

endpackage
`default_nettype wire

// ----- sv/command_line_tokenizer.sv -----
// command line tokenizer
// req channel: one byte of a command line per beat (character, has_character,
// end_of_line, line_number). a beat with has_character low and end_of_line high
// just closes the line; with both low it does nothing.
// rsp channel: token records (command name, arguments, types) as each token
// completes, then one status record at end of line. last_of_run marks the final
// record caused by one request beat; a beat causes zero to three records.
// a beat's records are written into the queue when the beat is accepted and
// are offered only once the record sequencer has loaded them from its head.
// throughput: one request beat per cycle while the queue is not full; the response
// side sends a beat's records one per cycle while rsp_ready is high.
// a four-entry queue sits between the classifier and the record sequencer, so a
// stalled receiver only backs up req_ready once that queue is full.
// reset: synchronous, clears the line state (expecting a command name, column
// zero, no failure) and drops queued and pending records.
// over MAX_LINE bytes: too long if not failed yet; later bytes are not counted
`default_nettype none
module command_line_tokenizer import clt_pkg::*; #(
   parameter int MAX_LINE = 1024
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire req_type  req_data,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output rsp_type       rsp_data
);

   logic        queue_full;
   logic        queue_empty;
   logic        push_valid;
   logic        queue_pop;
   bundle_type  push_data;
   bundle_type  queue_head;

   clt_front #(.MAX_LINE(MAX_LINE)) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .queue_full(queue_full),
      .push_valid(push_valid),
      .push_data(push_data)
   );

   clt_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_data(push_data),
      .full(queue_full),
      .empty(queue_empty),
      .head(queue_head),
      .pop(queue_pop)
   );

   clt_back u_back (
      .clock(clock),
      .reset(reset),
      .queue_empty(queue_empty),
      .queue_head(queue_head),
      .queue_pop(queue_pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

endmodule
`default_nettype wire

// ----- sv/clt_front.sv -----
`default_nettype none
module clt_front import clt_pkg::*; #(
   parameter int MAX_LINE = 1024
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire req_type    req_data,
   input  wire logic       queue_full,
   output logic            push_valid,
   output bundle_type      push_data
);

   localparam int COL_W = $clog2(MAX_LINE + 1);
   localparam int TS_W = $clog2(MAX_LINE);

   phase_type          phase_ff, phase_in;
   logic [TS_W-1:0]    token_start_ff, token_start_in;
   logic [COL_W-1:0]   column_ff, column_in;
   fail_type           fail_ff, fail_in;

   phase_type          ph;
   logic [TS_W-1:0]    ts;
   fail_type           fc;
   logic [COL_W-1:0]   col_next;
   logic [COL_W-1:0]   len;
   logic [7:0]         c;
   logic               again;
   logic               is_lower;
   logic               is_num;
   bundle_type         bundle;
   logic               accept;

   assign req_ready = !queue_full;
   assign accept = req_valid && req_ready;

   always_comb begin
      ph = phase_ff;
      ts = token_start_ff;
      fc = fail_ff;
      col_next = column_ff;
      len = '0;
      c = req_data.character;
      is_lower = (c >= CH_A) && (c <= CH_Z);
      is_num = (c >= CH_0) && (c <= CH_9);
      again = 1'b0;
      bundle = '0;
      bundle.line = req_data.line_number;

      if (req_data.has_character) begin
         if (column_ff >= COL_W'(MAX_LINE)) begin
            if (fc == FAIL_NONE) fc = FAIL_LONG;
         end else begin
            col_next = column_ff + 1'b1;
            again = (fc == FAIL_NONE);
         end
      end

      // a byte can end one token and start the next, so a few passes
      for (int i = 0; i < 4; i++) begin
         if (again && fc == FAIL_NONE) begin
            again = 1'b0;
            case (ph)
               PH_START: begin
                  if (is_lower) begin
                     ph = PH_CNAME;
                     ts = column_ff[TS_W-1:0];
                  end else begin
                     fc = FAIL_NONAME;
                  end
               end
               PH_CNAME: begin
                  if (!is_lower) begin
                     len = column_ff - COL_W'(ts);
                     if (c == CH_COLON) len = len + 1'b1;
                     else again = 1'b1;
                     bundle.recs[0] = '{1'b1, KIND_CMD, 10'(ts), 11'(len)};
                     ph = PH_ARGS;
                  end
               end
               PH_ARGS: begin
                  if (c != CH_BLANK) begin
                     ts = column_ff[TS_W-1:0];
                     if (is_lower) ph = PH_NAMEARG;
                     else if (is_num) ph = PH_NUMARG;
                     else if (c == CH_DOLLAR) ph = PH_DOLLAR;
                     else fc = FAIL_BAD;
                  end
               end
               PH_NAMEARG, PH_NUMARG: begin
                  if (!((ph == PH_NAMEARG) ? is_lower : is_num)) begin
                     len = column_ff - COL_W'(ts);
                     bundle.recs[0] = '{1'b1,
                        (ph == PH_NAMEARG) ? KIND_NAME_ARG : KIND_NUM_ARG,
                        10'(ts), 11'(len)};
                     ph = PH_VALDONE;
                     again = 1'b1;
                  end
               end
               PH_DOLLAR: begin
                  if (c == CH_DOLLAR) begin
                     bundle.recs[0] = '{1'b1, KIND_LAST_RESULT, 10'(ts), 11'd2};
                     ph = PH_VALDONE;
                  end else begin
                     fc = FAIL_BAD;
                  end
               end
               PH_VALDONE: begin
                  if (c == CH_HASH) begin
                     ph = PH_HASH;
                     ts = column_ff[TS_W-1:0];
                  end else begin
                     ph = PH_ARGS;
                     again = 1'b1;
                  end
               end
               PH_HASH: begin
                  if (is_lower) ph = PH_TYPE;
                  else fc = FAIL_BAD;
               end
               PH_TYPE: begin
                  if (!is_lower) begin
                     len = column_ff - COL_W'(ts);
                     bundle.recs[0] = '{1'b1, KIND_TYPE, 10'(ts), 11'(len)};
                     ph = PH_ARGS;
                     again = 1'b1;
                  end
               end
               default: begin
                  ph = PH_START;
                  fc = FAIL_BAD;
               end
            endcase
         end
      end

      if (req_data.end_of_line) begin
         len = col_next - COL_W'(ts);
         if (fc == FAIL_NONE) begin
            case (ph)
               PH_START: fc = FAIL_NONAME;
               PH_CNAME: bundle.recs[1] = '{1'b1, KIND_CMD, 10'(ts), 11'(len)};
               PH_NAMEARG:
                  bundle.recs[1] = '{1'b1, KIND_NAME_ARG, 10'(ts), 11'(len)};
               PH_NUMARG:
                  bundle.recs[1] = '{1'b1, KIND_NUM_ARG, 10'(ts), 11'(len)};
               PH_TYPE: bundle.recs[1] = '{1'b1, KIND_TYPE, 10'(ts), 11'(len)};
               PH_DOLLAR, PH_HASH: fc = FAIL_BAD;
               default: ;
            endcase
         end
         bundle.recs[2].valid = 1'b1;
         case (fc)
            FAIL_NONAME: bundle.recs[2].kind = KIND_NO_NAME;
            FAIL_BAD:    bundle.recs[2].kind = KIND_BAD_ARG;
            FAIL_LONG:   bundle.recs[2].kind = KIND_TOO_LONG;
            default:     bundle.recs[2].kind = KIND_OK;
         endcase
      end

      phase_in = phase_ff;
      token_start_in = token_start_ff;
      column_in = column_ff;
      fail_in = fail_ff;
      if (accept) begin
         if (req_data.end_of_line) begin
            phase_in = PH_START;
            token_start_in = '0;
            column_in = '0;
            fail_in = FAIL_NONE;
         end else begin
            phase_in = ph;
            token_start_in = ts;
            column_in = col_next;
            fail_in = fc;
         end
      end
   end

   assign push_data = bundle;
   assign push_valid = accept && (bundle.recs[0].valid || bundle.recs[1].valid
                                  || bundle.recs[2].valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         token_start_ff <= '0;
         column_ff <= '0;
         fail_ff <= FAIL_NONE;
      end else begin
         phase_ff <= phase_in;
         token_start_ff <= token_start_in;
         column_ff <= column_in;
         fail_ff <= fail_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/clt_queue.sv -----
`default_nettype none
module clt_queue import clt_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push_valid,
   input  wire bundle_type  push_data,
   output logic             full,
   output logic             empty,
   output bundle_type       head,
   input  wire logic        pop
);

   bundle_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]         count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign full = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head = slot_ff[rd_ptr_ff];
   assign do_push = push_valid && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/clt_back.sv -----
`default_nettype none
module clt_back import clt_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        queue_empty,
   input  wire bundle_type  queue_head,
   output logic             queue_pop,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data
);

   bundle_type                 cur_ff, cur_in;
   logic [RECS_PER_ITEM-1:0]   rem_ff, rem_in;
   logic [RECS_PER_ITEM-1:0]   rem_after;
   logic [RECS_PER_ITEM-1:0]   first;
   rec_type                    sel;
   logic                       load;

   // lowest pending record goes out first
   assign first = rem_ff & (~rem_ff + 1'b1);
   assign rem_after = rem_ff & ~first;

   always_comb begin
      sel = '0;
      for (int i = 0; i < RECS_PER_ITEM; i++) begin
         if (first[i]) sel = cur_ff.recs[i];
      end
   end

   assign rsp_valid = |rem_ff;
   assign rsp_data = '{sel.kind, sel.start, sel.len, cur_ff.line, ~|rem_after};

   always_comb begin
      load = (rem_ff == '0) || (rsp_ready && rem_after == '0);
      queue_pop = load && !queue_empty;
      cur_in = cur_ff;
      rem_in = rem_ff;
      if (rsp_valid && rsp_ready) rem_in = rem_after;
      if (queue_pop) begin
         cur_in = queue_head;
         for (int i = 0; i < RECS_PER_ITEM; i++) rem_in[i] = queue_head.recs[i].valid;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

endmodule
`default_nettype wire

// ----- bench/line_record_checker.sv -----
module line_record_checker import clt_pkg::*; #(
   parameter int MAX_LINE = 1024
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_ready,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_ready,
   input  wire rsp_type rsp_data,
   output int           fail_count,
   output int           records_checked,
   output int           waiting,
   output logic [8:0]   kinds_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   // line state of the tokenizer as predicted here
   phase_type ph;
   int        tok_start;
   int        col_count;
   fail_type  cause;
   logic      line_failed;

   rsp_type beat_records[$];
   rsp_type pending_records[$];

   function automatic bit lower_char(logic [7:0] c);
      return c >= CH_A && c <= CH_Z;
   endfunction

   function automatic bit num_char(logic [7:0] c);
      return c >= CH_0 && c <= CH_9;
   endfunction

   task automatic clear_line();
      ph = PH_START;
      tok_start = 0;
      col_count = 0;
      cause = FAIL_NONE;
      line_failed = 1'b0;
   endtask

   task automatic mark_failed(fail_type why);
      if (!line_failed) begin
         line_failed = 1'b1;
         cause = why;
      end
   endtask

   task automatic emit(logic [3:0] kind, int start, int len, logic [15:0] ln);
      rsp_type r;
      r.record_kind = kind;
      r.start_column = start[9:0];
      r.token_length = len[10:0];
      r.line_echo = ln;
      r.last_of_run = 1'b0;
      beat_records.insert(beat_records.size(), r);
   endtask

   task automatic take_char(logic [7:0] c, int col, logic [15:0] ln);
      bit again;
      int guard;
      again = 1'b1;
      guard = 0;
      // a byte that ends one token is looked at again as the start of the next
      while (again && guard < 4 && !line_failed) begin
         again = 1'b0;
         guard++;
         case (ph)
            PH_START: begin
               if (lower_char(c)) begin
                  ph = PH_CNAME;
                  tok_start = col;
               end else begin
                  mark_failed(FAIL_NONAME);
               end
            end
            PH_CNAME: begin
               if (!lower_char(c)) begin
                  if (c == CH_COLON) begin
                     emit(KIND_CMD, tok_start, col - tok_start + 1, ln);
                  end else begin
                     emit(KIND_CMD, tok_start, col - tok_start, ln);
                     again = 1'b1;
                  end
                  ph = PH_ARGS;
               end
            end
            PH_ARGS: begin
               if (c != CH_BLANK) begin
                  tok_start = col;
                  if (lower_char(c)) ph = PH_NAMEARG;
                  else if (num_char(c)) ph = PH_NUMARG;
                  else if (c == CH_DOLLAR) ph = PH_DOLLAR;
                  else mark_failed(FAIL_BAD);
               end
            end
            PH_NAMEARG, PH_NUMARG: begin
               if (ph == PH_NAMEARG ? !lower_char(c) : !num_char(c)) begin
                  emit(ph == PH_NAMEARG ? KIND_NAME_ARG : KIND_NUM_ARG,
                       tok_start, col - tok_start, ln);
                  ph = PH_VALDONE;
                  again = 1'b1;
               end
            end
            PH_DOLLAR: begin
               if (c == CH_DOLLAR) begin
                  emit(KIND_LAST_RESULT, tok_start, 2, ln);
                  ph = PH_VALDONE;
               end else begin
                  mark_failed(FAIL_BAD);
               end
            end
            PH_VALDONE: begin
               if (c == CH_HASH) begin
                  ph = PH_HASH;
                  tok_start = col;
               end else begin
                  ph = PH_ARGS;
                  again = 1'b1;
               end
            end
            PH_HASH: begin
               if (lower_char(c)) ph = PH_TYPE;
               else mark_failed(FAIL_BAD);
            end
            PH_TYPE: begin
               if (!lower_char(c)) begin
                  emit(KIND_TYPE, tok_start, col - tok_start, ln);
                  ph = PH_ARGS;
                  again = 1'b1;
               end
            end
            default: begin
               ph = PH_START;
               mark_failed(FAIL_BAD);
            end
         endcase
      end
   endtask

   task automatic close_line(logic [15:0] ln);
      int len;
      logic [3:0] status;
      len = col_count - tok_start;
      // an open token is flushed by the end of the line
      if (!line_failed) begin
         case (ph)
            PH_START: mark_failed(FAIL_NONAME);
            PH_CNAME: emit(KIND_CMD, tok_start, len, ln);
            PH_NAMEARG: emit(KIND_NAME_ARG, tok_start, len, ln);
            PH_NUMARG: emit(KIND_NUM_ARG, tok_start, len, ln);
            PH_TYPE: emit(KIND_TYPE, tok_start, len, ln);
            PH_DOLLAR, PH_HASH: mark_failed(FAIL_BAD);
            default: ;
         endcase
      end
      case (cause)
         FAIL_NONAME: status = KIND_NO_NAME;
         FAIL_BAD: status = KIND_BAD_ARG;
         FAIL_LONG: status = KIND_TOO_LONG;
         default: status = KIND_OK;
      endcase
      emit(status, 0, 0, ln);
      clear_line();
   endtask

   task automatic tokenize_beat(req_type beat);
      beat_records.delete();
      if (beat.has_character) begin
         if (col_count >= MAX_LINE) begin
            mark_failed(FAIL_LONG);
         end else begin
            col_count++;
            if (!line_failed) take_char(beat.character, col_count - 1, beat.line_number);
         end
      end
      if (beat.end_of_line) close_line(beat.line_number);
      if (beat_records.size() > 0) beat_records[beat_records.size() - 1].last_of_run = 1'b1;
      foreach (beat_records[i]) pending_records.insert(pending_records.size(), beat_records[i]);
   endtask

   task automatic check_field(string what, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
         fail_count++;
      end
   endtask

   task automatic check_record(rsp_type got);
      rsp_type want;
      records_checked++;
      if (got.record_kind < 9) kinds_seen[got.record_kind] = 1'b1;
      if (pending_records.size() == 0) begin
         $display("%0t: unexpected record, expected none, got kind %0d col %0d len %0d line %0d",
                  $time, got.record_kind, got.start_column, got.token_length,
                  got.line_echo);
         fail_count++;
      end else begin
         want = pending_records.pop_front();
         check_field("record_kind", 16'(want.record_kind), 16'(got.record_kind));
         check_field("start_column", 16'(want.start_column), 16'(got.start_column));
         check_field("token_length", 16'(want.token_length), 16'(got.token_length));
         check_field("line_echo", want.line_echo, got.line_echo);
         check_field("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_line();
         pending_records.delete();
         fail_count = 0;
         records_checked = 0;
         kinds_seen = '0;
      end else begin
         if (req_valid && req_ready) tokenize_beat(req_data);
         if (rsp_valid && rsp_ready) check_record(rsp_data);
      end
      waiting <= pending_records.size();
   end

endmodule

// ----- bench/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import clt_pkg::*;

   localparam int MAX_LINE = 1024;
   localparam int IDLE_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_BEATS = 25;
   localparam int TAIL_CYCLES = 20;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int         fail_count;
   int         records_checked;
   int         waiting;
   logic [8:0] kinds_seen;

   logic [7:0] line_buf[$];
   int beats_sent = 0;
   int ignored_sent = 0;
   int lines_sent = 0;
   int burst_left = 0;
   bit tx_steady = 1'b0;
   bit rx_steady = 1'b0;
   int hold_asks = 0;

   int hold_seen = 0;
   int hold_left = 0;
   int run_left = 0;
   bit ready_run = 1'b0;
   int quiet_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   command_line_tokenizer #(.MAX_LINE(MAX_LINE)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   line_record_checker #(.MAX_LINE(MAX_LINE)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .fail_count      (fail_count),
      .records_checked (records_checked),
      .waiting         (waiting),
      .kinds_seen      (kinds_seen)
   );

   // receiver: alternating ready and stall runs, a long hold when asked, or steady ready
   always @(posedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (rx_steady) begin
         rsp_ready <= 1'b1;
      end else begin
         if (run_left == 0) begin
            ready_run = !ready_run;
            run_left = ready_run ? $urandom_range(1, 10) : $urandom_range(1, 4);
         end
         run_left--;
         rsp_ready <= ready_run;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_beat(req_type beat);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = (tx_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (!req_ready);
   endtask

   // one line, a byte per beat, optional ignored beats; byteless end beat if asked or empty
   task automatic send_line(logic [15:0] ln, bit split_end, bit sprinkle);
      req_type beat;
      for (int i = 0; i < line_buf.size(); i++) begin
         if (sprinkle && $urandom_range(0, 9) == 0) begin
            beat.character = 8'($urandom_range(0, 255));
            beat.has_character = 1'b0;
            beat.end_of_line = 1'b0;
            beat.line_number = 16'($urandom);
            send_beat(beat);
            ignored_sent++;
         end
         beat.character = line_buf[i];
         beat.has_character = 1'b1;
         beat.end_of_line = (i == line_buf.size() - 1) && !split_end;
         beat.line_number = ln;
         send_beat(beat);
         beats_sent++;
      end
      if (split_end || line_buf.size() == 0) begin
         beat.character = 8'($urandom_range(0, 255));
         beat.has_character = 1'b0;
         beat.end_of_line = 1'b1;
         beat.line_number = ln;
         send_beat(beat);
         beats_sent++;
      end
      lines_sent++;
   endtask

   task automatic wait_for_records();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (waiting != 0);
   endtask

   task automatic add_byte(logic [7:0] b);
      line_buf.insert(line_buf.size(), b);
   endtask

   task automatic load(string s);
      line_buf.delete();
      foreach (s[i]) add_byte(s[i]);
   endtask

   task automatic add_letters(int n);
      repeat (n) add_byte(8'(CH_A + $urandom_range(0, 25)));
   endtask

   task automatic add_digits(int n);
      repeat (n) add_byte(8'(CH_0 + $urandom_range(0, 9)));
   endtask

   // mostly well-formed commands, some corrupted or cut short, some raw noise
   task automatic build_random_line();
      int style;
      line_buf.delete();
      style = $urandom_range(0, 9);
      if (style == 0) begin
         repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)));
      end else begin
         add_letters($urandom_range(1, 4));
         if ($urandom_range(0, 1)) add_byte(CH_COLON);
         repeat ($urandom_range(0, 4)) begin
            repeat ($urandom_range(0, 2)) add_byte(CH_BLANK);
            case ($urandom_range(0, 2))
               0: add_letters($urandom_range(1, 3));
               1: add_digits($urandom_range(1, 3));
               default: begin
                  add_byte(CH_DOLLAR);
                  add_byte(CH_DOLLAR);
               end
            endcase
            if ($urandom_range(0, 2) == 0) begin
               add_byte(CH_HASH);
               add_letters($urandom_range(1, 2));
            end
         end
         repeat ($urandom_range(0, 2)) add_byte(CH_BLANK);
         if (style == 1)
            line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
         else if (style == 2)
            add_byte($urandom_range(0, 1) ? CH_DOLLAR : CH_HASH);
      end
   endtask

   initial begin
      int random_from;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // missing names, every token kind, bad arguments, first failure wins
      load(":");
      send_line(16'h0000, 1'b0, 1'b0);
      line_buf.delete();
      send_line(16'hffff, 1'b0, 1'b0);
      load("a1$$#t");
      send_line(16'($urandom), 1'b0, 1'b0);
      load("b: c ");
      send_line(16'($urandom), 1'b1, 1'b0);
      load("x $y");
      send_line(16'($urandom), 1'b0, 1'b0);
      load("x 1#2 a");
      send_line(16'($urandom), 1'b0, 1'b0);
      load("x");
      add_byte(8'hff);
      send_line(16'($urandom), 1'b0, 1'b0);
      line_buf.delete();
      add_byte(8'h00);
      send_line(16'($urandom), 1'b0, 1'b0);
      wait_for_records();

      // receiver holds off while beats keep coming, so the input backs up
      hold_asks++;
      tx_steady = 1'b1;
      repeat (24) begin
         line_buf.delete();
         add_letters(1);
         send_line(16'($urandom), 1'b0, 1'b0);
      end
      wait_for_records();

      // mixed lines with no idling on either side
      rx_steady = 1'b1;
      load("run: ab 12 $$#t x#q");
      send_line(16'($urandom), 1'b0, 1'b0);
      load("z 7 ");
      send_line(16'($urandom), 1'b1, 1'b0);
      wait_for_records();
      tx_steady = 1'b0;
      rx_steady = 1'b0;

      random_from = beats_sent;
      while (beats_sent - random_from < RANDOM_BEATS) begin
         build_random_line();
         send_line(16'($urandom), $urandom_range(0, 3) == 0, 1'b1);
      end

      wait_for_records();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("sent %0d byte beats plus %0d ignored beats over %0d lines, %0d records checked",
               beats_sent, ignored_sent, lines_sent, records_checked);
      $display("record kinds seen (bit per kind): %b, with a long receiver hold and steady runs",
               kinds_seen);
      if (waiting != 0) $display("%0t: %0d records never arrived", $time, waiting);
      if (fail_count == 0 && waiting == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
